>>> rtl/jse_pkg.sv
// ----------------------------------------------------------------------------
// JSON string escaper package
// Shared types, character constants and helper functions.
// ----------------------------------------------------------------------------
package jse_pkg;

  // How one accepted item is to be expanded by the back end.
  typedef enum logic [1:0] {
    K_PLAIN,
    K_SHORT,
    K_UNICODE,
    K_END
  } kind_e;

  // Classified item as it travels through the queue. The code holds the
  // plain byte, the escape letter, or the raw control byte.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] code;
  } entry_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_ROOM = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  localparam logic [15:0] CAP_RESET = 16'd256;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6e;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;

  localparam logic [7:0] BYTE_BS  = 8'h08;
  localparam logic [7:0] BYTE_TAB = 8'h09;
  localparam logic [7:0] BYTE_LF  = 8'h0a;
  localparam logic [7:0] BYTE_FF  = 8'h0c;
  localparam logic [7:0] BYTE_CR  = 8'h0d;
  localparam logic [7:0] CTRL_LIM = 8'h20;

  localparam int unsigned STEP_W = 3;

  // Lowercase hex digit for one nibble.
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] wide;
    wide = {4'b0000, nib};
    if (nib < 4'd10) begin
      hex_char = CH_ZERO + wide;
    end else begin
      hex_char = 8'h57 + wide;
    end
  endfunction

  // Index of the final body character of an entry.
  function automatic logic [STEP_W-1:0] last_step(input kind_e kind);
    case (kind)
      K_SHORT:   last_step = STEP_W'(1);
      K_UNICODE: last_step = STEP_W'(5);
      default:   last_step = STEP_W'(0);
    endcase
  endfunction

  // Body character of an entry at a given step.
  function automatic logic [7:0] body_char(input entry_t ent, input logic [STEP_W-1:0] step);
    logic [7:0] ch;
    ch = ent.code;
    case (ent.kind)
      K_SHORT: begin
        ch = (step == STEP_W'(0)) ? CH_BSL : ent.code;
      end
      K_UNICODE: begin
        case (step)
          STEP_W'(0): ch = CH_BSL;
          STEP_W'(1): ch = CH_U;
          STEP_W'(2): ch = CH_ZERO;
          STEP_W'(3): ch = CH_ZERO;
          STEP_W'(4): ch = hex_char(ent.code[7:4]);
          default:    ch = hex_char(ent.code[3:0]);
        endcase
      end
      K_END:   ch = CH_QUOTE;
      default: ch = ent.code;
    endcase
    body_char = ch;
  endfunction

endpackage

>>> rtl/jse_in_if.sv
// ----------------------------------------------------------------------------
// JSON string escaper input channel
// Valid/ready channel carrying one string byte or an end marker.
// ----------------------------------------------------------------------------
interface jse_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink   (input valid, input op, input data_byte, output ready);
endinterface

>>> rtl/jse_out_if.sv
// ----------------------------------------------------------------------------
// JSON string escaper output channel
// Valid/ready channel carrying one output character with status.
// ----------------------------------------------------------------------------
interface jse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic [1:0] status;
  logic       last;

  modport source (output valid, output out_char, output status, output last, input ready);
  modport sink   (input valid, input out_char, input status, input last, output ready);
endinterface

>>> rtl/jse_front.sv
// ----------------------------------------------------------------------------
// JSON string escaper front end
// Accepts input transfers and classifies each byte by its escape form.
// ----------------------------------------------------------------------------
module jse_front
  import jse_pkg::*;
(
  jse_in_if.sink in_i,
  input  logic   full_i,
  output logic   push_o,
  output entry_t entry_o
);

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  always_comb begin
    entry_o.kind = K_PLAIN;
    entry_o.code = in_i.data_byte;
    if (in_i.op) begin
      entry_o.kind = K_END;
      entry_o.code = CH_QUOTE;
    end else begin
      case (in_i.data_byte)
        CH_QUOTE: entry_o.kind = K_SHORT;
        CH_BSL:   entry_o.kind = K_SHORT;
        BYTE_BS: begin
          entry_o.kind = K_SHORT;
          entry_o.code = CH_B;
        end
        BYTE_FF: begin
          entry_o.kind = K_SHORT;
          entry_o.code = CH_F;
        end
        BYTE_LF: begin
          entry_o.kind = K_SHORT;
          entry_o.code = CH_N;
        end
        BYTE_CR: begin
          entry_o.kind = K_SHORT;
          entry_o.code = CH_R;
        end
        BYTE_TAB: begin
          entry_o.kind = K_SHORT;
          entry_o.code = CH_T;
        end
        default: begin
          if (in_i.data_byte < CTRL_LIM) begin
            entry_o.kind = K_UNICODE;
          end
        end
      endcase
    end
  end

endmodule

>>> rtl/jse_queue.sv
// ----------------------------------------------------------------------------
// JSON string escaper queue
// Two-entry queue of classified items between front end and back end.
// ----------------------------------------------------------------------------
module jse_queue
  import jse_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   head_vld_o,
  output entry_t head_o
);

  entry_t     slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o     = (count_q == 2'd2);
  assign head_vld_o = (count_q != 2'd0);
  assign head_o     = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = !wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = !rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

>>> rtl/jse_back.sv
// ----------------------------------------------------------------------------
// JSON string escaper back end
// Expands queued items into output characters, one per cycle while out_o
// is ready, and keeps the per-string count and error state.
// ----------------------------------------------------------------------------
module jse_back
  import jse_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] capacity_i,
  input  logic        head_vld_i,
  input  entry_t      head_i,
  output logic        pop_o,
  jse_out_if.source   out_o
);

  logic              started_q, started_d;
  logic              failed_q, failed_d;
  logic [15:0]       used_q, used_d;
  logic [STEP_W-1:0] step_q, step_d;

  logic              out_vld_q, out_vld_d;
  logic [7:0]        out_char_q;
  logic [1:0]        out_stat_q;
  logic              out_last_q;

  logic              emit, want_pop, go, out_free, is_end, room, opening;
  logic [7:0]        e_char, put_char;
  logic [1:0]        e_stat;
  logic              e_last;

  assign out_o.valid    = out_vld_q;
  assign out_o.out_char = out_char_q;
  assign out_o.status   = out_stat_q;
  assign out_o.last     = out_last_q;

  assign out_free = !out_vld_q || out_o.ready;
  assign is_end   = (head_i.kind == K_END);
  assign room     = ({1'b0, used_q} + 17'd1) < {1'b0, capacity_i};
  assign opening  = !started_q;
  assign put_char = opening ? CH_QUOTE : body_char(head_i, step_q);

  always_comb begin
    emit      = 1'b0;
    want_pop  = 1'b0;
    e_char    = 8'h00;
    e_stat    = ST_OK;
    e_last    = 1'b0;
    started_d = started_q;
    failed_d  = failed_q;
    used_d    = used_q;
    step_d    = step_q;

    if (head_vld_i) begin
      if (failed_q) begin
        want_pop = 1'b1;
      end else if (capacity_i == 16'd0) begin
        emit      = 1'b1;
        e_stat    = ST_INVALID;
        e_last    = 1'b1;
        want_pop  = 1'b1;
        failed_d  = 1'b1;
        started_d = 1'b1;
      end else if (!room) begin
        // Out of room: one error result, the rest of the item is dropped.
        emit     = 1'b1;
        e_stat   = ST_NO_ROOM;
        e_last   = 1'b1;
        failed_d = 1'b1;
        want_pop = !opening;
        step_d   = '0;
      end else begin
        emit   = 1'b1;
        e_char = put_char;
        used_d = used_q + 16'd1;
        if (opening) begin
          started_d = 1'b1;
        end else if (is_end) begin
          e_last   = 1'b1;
          want_pop = 1'b1;
        end else if (step_q == last_step(head_i.kind)) begin
          want_pop = 1'b1;
          step_d   = '0;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      // An end marker that finishes always starts the next string fresh.
      if (is_end && want_pop) begin
        started_d = 1'b0;
        failed_d  = 1'b0;
        used_d    = 16'd0;
        step_d    = '0;
      end
    end

    go        = head_vld_i && (out_free || !emit);
    pop_o     = go && want_pop;
    out_vld_d = out_vld_q && !out_o.ready;
    if (go && emit) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      failed_q  <= 1'b0;
      used_q    <= 16'd0;
      step_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      if (go) begin
        started_q <= started_d;
        failed_q  <= failed_d;
        used_q    <= used_d;
        step_q    <= step_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && emit) begin
      out_char_q <= e_char;
      out_stat_q <= e_stat;
      out_last_q <= e_last;
    end
  end

endmodule

>>> rtl/json_string_escaper_unit.sv
// ----------------------------------------------------------------------------
// JSON string escaper
// Turns a byte stream with end markers into its quoted, escaped JSON form.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Payload                      Handshake
//   in_i      sink       op, data_byte                valid/ready
//   out_o     source     out_char, status, last       valid/ready
//   cfg       write      cfg_data_i (capacity)        cfg_we_i, no wait
//
// Plain bytes inside a string flow at one transfer per cycle while out_o
// accepts; the back end sequencer emits one character per cycle unless
// out_o stalls. It opens each string with a quote, expands escapes to a
// backslash and letter or to \u00XX, closes the string with a quote on an
// end marker and emits nothing for a dropped byte. Reset is asynchronous
// and active low; it clears the string state and loads capacity with 256.
// A two-entry queue lets the input keep accepting while out_o stalls.
//
module json_string_escaper_unit
  import jse_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i,
  jse_in_if.sink      in_i,
  jse_out_if.source   out_o
);

  // Capacity is read at every item, so a new value applies at once.
  logic [15:0] capacity_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      capacity_q <= cfg_data_i;
    end
  end

  // Front end: classifies each accepted byte by the escape it needs.
  logic   push, full;
  entry_t push_entry;

  jse_front u_front (
    .in_i    (in_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (push_entry)
  );

  // Queue decouples acceptance from expansion.
  logic   pop, head_vld;
  entry_t head;

  jse_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .entry_i    (push_entry),
    .full_o     (full),
    .pop_i      (pop),
    .head_vld_o (head_vld),
    .head_o     (head)
  );

  // Back end: holds started, count and failure state and drives the
  // output register, one character per transfer.
  jse_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .capacity_i (capacity_q),
    .head_vld_i (head_vld),
    .head_i     (head),
    .pop_o      (pop),
    .out_o      (out_o)
  );

endmodule
